/* design/brs_pkg.sv */
// brs_pkg: shared sizes, opcodes, item structs and controller/datapath types
// for the block decomposed range sum unit. No dependencies.
package brs_pkg;

   // store geometry; BLOCK_SIZE and DEPTH are powers of two
   localparam int DEPTH      = 1024;
   localparam int BLOCK_SIZE = 32;
   localparam int NUM_BLOCKS = (DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;

   localparam int FIELD_IDX_W = 10;
   localparam int VALUE_W     = 32;
   localparam int SUM_W       = 64;
   localparam int BSUM_W      = 42;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int OFS_W  = $clog2(BLOCK_SIZE);
   localparam int BLK_W  = $clog2(NUM_BLOCKS);
   // walk counter must hold indices up to last + BLOCK_SIZE
   localparam int CNT_W  = ADDR_W + 1;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic                          op;
      logic [FIELD_IDX_W-1:0]        first_index;
      logic [FIELD_IDX_W-1:0]        last_index;
      logic signed [VALUE_W-1:0]     value;
   } brs_req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] range_sum;
      logic                    range_error;
   } brs_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_READ,
      ST_UPD_WRITE,
      ST_QUERY,
      ST_DRAIN
   } brs_state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic upd_read;
      logic upd_write;
      logic issue_elem;
      logic issue_block;
      logic respond;
   } brs_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic upd_in_range;
      logic walk_done;
      logic block_ok;
   } brs_stat_type;

endpackage

/* design/block_decomposed_range_sum_unit.sv */
// block_decomposed_range_sum_unit: range sums with point updates over 1024
// elements in blocks of 32. Update: busy through a read state and a write state,
// no result, next item taken once idle again. Query: one memory read per cycle
// (leading edge elements, whole-block sums, trailing edge elements), up to 92
// reads; the result strobes after a drain state, cannot be stalled, next item accepted right then.
// Reset: a clearing pass of both stores with busy high.
module block_decomposed_range_sum_unit
   import brs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  brs_req_type req_item,
   output logic        rsp_valid,
   output brs_rsp_type rsp_item
);

   brs_cmd_type  cmd;
   brs_stat_type stat;

   brs_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_item.op),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   brs_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

/* design/brs_datapath.sv */
// brs_datapath: element store, block sum store, walk index, accumulator and
// result register. Driven by brs_controller; uses brs_pkg.
module brs_datapath
   import brs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  brs_req_type  req_item,
   input  brs_cmd_type  cmd,
   output brs_stat_type stat,
   output logic         rsp_valid,
   output brs_rsp_type  rsp_item
);

   logic [VALUE_W-1:0] elem_mem [DEPTH];
   logic [BSUM_W-1:0]  bsum_mem [NUM_BLOCKS];

   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   last_ff, last_in;
   logic [VALUE_W-1:0] value_ff;
   logic               err_ff;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic               pend_elem_ff, pend_block_ff;
   logic [VALUE_W-1:0] elem_rd_ff;
   logic [BSUM_W-1:0]  bsum_rd_ff;
   logic               rsp_valid_ff;
   brs_rsp_type        rsp_item_ff;

   logic [ADDR_W-1:0]  elem_addr;
   logic [BLK_W-1:0]   blk_addr;
   logic               elem_we, bsum_we;
   logic [VALUE_W-1:0] elem_wdata;
   logic [BSUM_W-1:0]  bsum_wdata;
   logic [CNT_W-1:0]   block_end;

   assign elem_addr = idx_ff[ADDR_W-1:0];
   assign blk_addr  = idx_ff[ADDR_W-1:OFS_W];

   // clamp the query end to the last stored element
   always_comb begin
      if ({1'b0, req_item.last_index} > CNT_W'(DEPTH - 1)) begin
         last_in = CNT_W'(DEPTH - 1);
      end else begin
         last_in = CNT_W'(req_item.last_index);
      end
   end

   assign block_end = idx_ff + CNT_W'(BLOCK_SIZE - 1);

   always_comb begin
      stat.sweep_last   = (idx_ff == CNT_W'(DEPTH - 1));
      stat.upd_in_range = (idx_ff < CNT_W'(DEPTH));
      stat.walk_done    = (idx_ff > last_ff);
      stat.block_ok     = (idx_ff[OFS_W-1:0] == '0) && (block_end <= last_ff);
   end

   always_comb begin
      elem_we    = cmd.clear | cmd.upd_write;
      elem_wdata = cmd.clear ? '0 : value_ff;
      // block sums live only in the first NUM_BLOCKS steps of the sweep
      bsum_we    = (cmd.clear && (idx_ff[CNT_W-1:BLK_W] == '0)) | cmd.upd_write;
      bsum_wdata = cmd.clear ? '0
                 : bsum_rd_ff + BSUM_W'($signed(value_ff))
                              - BSUM_W'($signed(elem_rd_ff));
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_addr] <= elem_wdata;
      end
      if (cmd.upd_read || cmd.issue_elem) begin
         elem_rd_ff <= elem_mem[elem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (bsum_we) begin
         bsum_mem[cmd.clear ? idx_ff[BLK_W-1:0] : blk_addr] <= bsum_wdata;
      end
      if (cmd.upd_read || cmd.issue_block) begin
         bsum_rd_ff <= bsum_mem[blk_addr];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = CNT_W'(req_item.first_index);
      end else if (cmd.issue_block) begin
         idx_in = idx_ff + CNT_W'(BLOCK_SIZE);
      end else if (cmd.clear || cmd.issue_elem) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.load) begin
         acc_in = '0;
      end else if (pend_elem_ff) begin
         acc_in = acc_ff + SUM_W'($signed(elem_rd_ff));
      end else if (pend_block_ff) begin
         acc_in = acc_ff + SUM_W'($signed(bsum_rd_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         pend_elem_ff  <= 1'b0;
         pend_block_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         pend_elem_ff  <= cmd.issue_elem;
         pend_block_ff <= cmd.issue_block;
         rsp_valid_ff  <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.load) begin
         last_ff  <= last_in;
         value_ff <= req_item.value;
         err_ff   <= (req_item.first_index > req_item.last_index);
      end
      if (cmd.respond) begin
         rsp_item_ff.range_sum   <= acc_ff;
         rsp_item_ff.range_error <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

/* design/brs_controller.sv */
// brs_controller: sequencer for the clearing sweep, point updates and the
// range walk. Commands brs_datapath; uses brs_pkg.
module brs_controller
   import brs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         req_op,
   input  brs_stat_type stat,
   output brs_cmd_type  cmd,
   output logic         busy
);

   brs_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_op == OP_UPDATE) ? ST_UPD_READ : ST_QUERY;
            end
         end
         ST_UPD_READ: begin
            if (stat.upd_in_range) begin
               cmd.upd_read = 1'b1;
               state_in     = ST_UPD_WRITE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_UPD_WRITE: begin
            cmd.upd_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_QUERY: begin
            // whole aligned blocks use the stored sum, edges go by element
            if (stat.walk_done) begin
               state_in = ST_DRAIN;
            end else if (stat.block_ok) begin
               cmd.issue_block = 1'b1;
            end else begin
               cmd.issue_elem = 1'b1;
            end
         end
         ST_DRAIN: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* design/brs_checker.sv */
// brs_checker: port-level assertions for block_decomposed_range_sum_unit,
// attached by bind. Uses brs_pkg.
module brs_checker
   import brs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input brs_req_type req_item,
   input logic        rsp_valid,
   input brs_rsp_type rsp_item
);

   // an accepted item always occupies the unit for the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // clearing pass holds off input right after reset
   a_reset_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("not busy after reset");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.range_error) |-> (rsp_item.range_sum == '0))
      else $error("reversed range with nonzero sum");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

endmodule

bind block_decomposed_range_sum_unit brs_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

/* test/tb.sv */
// tb: self-checking testbench for block_decomposed_range_sum_unit, with point updates and
// range sum queries, random sender bursts and a predictor of both stores.
// Depends on brs_pkg and the unit's RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import brs_pkg::*;

   localparam int IDLE_LIMIT = 6000;
   localparam int TAIL_CYCLES = 100;
   localparam int RANDOM_ITEMS = 1280;

   typedef struct {
      brs_req_type item;
      bit          hold;   // wait until every query answer is in before sending
   } pending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   brs_req_type req_item = '0;
   logic        rsp_valid;
   brs_rsp_type rsp_item;

   block_decomposed_range_sum_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #1 clock = ~clock;

   // shadow copies of both stores
   logic signed [VALUE_W-1:0] element_shadow [DEPTH];
   logic signed [SUM_W-1:0]   block_sum_shadow [NUM_BLOCKS];

   pending_type pending_items [$];
   brs_rsp_type expected_sums [$];

   int unsigned items_queued = 0;
   int unsigned items_accepted = 0;
   int unsigned updates_seen = 0;
   int unsigned queries_seen = 0;
   int unsigned reversed_seen = 0;
   int unsigned spanning_seen = 0;
   int unsigned sums_checked = 0;
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;

   function automatic logic signed [SUM_W-1:0] element_run_sum(int lo, int hi);
      logic signed [SUM_W-1:0] acc;
      acc = '0;
      for (int i = lo; i <= hi && i < DEPTH; i++)
         acc += SUM_W'(element_shadow[i]);
      return acc;
   endfunction

   // updates the shadow stores and queues the answer of a query
   task automatic predict_item(brs_req_type it);
      brs_rsp_type ans;
      int first, last, sb, eb;
      first = it.first_index;
      last = it.last_index;
      ans = '0;
      if (it.op == OP_UPDATE) begin
         updates_seen++;
         if (first < DEPTH) begin
            sb = first / BLOCK_SIZE;
            block_sum_shadow[sb] = block_sum_shadow[sb] - SUM_W'(element_shadow[first])
                                   + SUM_W'(it.value);
            element_shadow[first] = it.value;
         end
         return;
      end
      queries_seen++;
      if (first > last) begin
         reversed_seen++;
         ans.range_error = 1'b1;
      end else begin
         if (last >= DEPTH) last = DEPTH - 1;
         if (first <= last) begin
            sb = first / BLOCK_SIZE;
            eb = last / BLOCK_SIZE;
            if (sb == eb) begin
               ans.range_sum = element_run_sum(first, last);
            end else begin
               spanning_seen++;
               ans.range_sum = element_run_sum(first, (sb + 1) * BLOCK_SIZE - 1);
               for (int b = sb + 1; b < eb; b++)
                  ans.range_sum += block_sum_shadow[b];
               ans.range_sum += element_run_sum(eb * BLOCK_SIZE, last);
            end
         end
      end
      expected_sums.push_back(ans);
   endtask

   task automatic add_item(logic op, int first, int last, logic [VALUE_W-1:0] val,
                           bit hold = 1'b0);
      pending_type p;
      p.item.op = op;
      p.item.first_index = first[FIELD_IDX_W-1:0];
      p.item.last_index = last[FIELD_IDX_W-1:0];
      p.item.value = val;
      p.hold = hold;
      pending_items.push_back(p);
      items_queued++;
   endtask

   function automatic int pick_index();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, NUM_BLOCKS - 1) * BLOCK_SIZE;
         1: return $urandom_range(0, NUM_BLOCKS - 1) * BLOCK_SIZE + BLOCK_SIZE - 1;
         2: return $urandom_range(0, 127);   // hot window keeps queries over live data
         default: return $urandom_range(0, DEPTH - 1);
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_random_query();
      int a, b, t;
      a = pick_index();
      case ($urandom_range(0, 9))
         0: b = $urandom_range(0, a);                     // reversed or single
         1, 2: b = (a / BLOCK_SIZE) * BLOCK_SIZE + $urandom_range(0, BLOCK_SIZE - 1);
         3: begin
            a = 0;
            b = DEPTH - 1;
         end
         default: begin
            b = pick_index();
            if (b < a && $urandom_range(0, 4) != 0) begin
               t = a;
               a = b;
               b = t;
            end
         end
      endcase
      add_item(OP_QUERY, a, b, $urandom);
   endtask

   // directed items, then random traffic
   initial begin
      int n, blk;
      add_item(OP_QUERY, 0, DEPTH - 1, 32'h0);
      add_item(OP_UPDATE, 0, 1023, 32'h7fff_ffff);
      add_item(OP_UPDATE, DEPTH - 1, 0, 32'h8000_0000);
      add_item(OP_UPDATE, 31, 0, 32'hffff_ffff);
      add_item(OP_UPDATE, 32, 1023, 32'h0000_0001);
      add_item(OP_UPDATE, 5, 0, 32'h1234_5678);
      add_item(OP_UPDATE, 5, 0, 32'hedcb_a988);   // overwrite must take old value out
      add_item(OP_UPDATE, 600, 7, 32'h7fff_ffff);
      add_item(OP_QUERY, 0, 0, 32'hffff_ffff);
      add_item(OP_QUERY, DEPTH - 1, DEPTH - 1, 32'h0);
      add_item(OP_QUERY, 31, 32, 32'h0);
      add_item(OP_QUERY, 5, 5, 32'h0);
      add_item(OP_QUERY, 3, 20, 32'h0);
      add_item(OP_QUERY, 0, 31, 32'h0);
      add_item(OP_QUERY, 32, 63, 32'h0);
      add_item(OP_QUERY, 10, 1000, 32'h0);
      add_item(OP_QUERY, 0, DEPTH - 1, 32'h0);
      add_item(OP_QUERY, DEPTH - 1, 0, 32'h0);    // reversed range
      add_item(OP_QUERY, 5, 4, 32'h0);
      add_item(OP_QUERY, 1, 1022, 32'h0);
      add_item(OP_QUERY, 31, 31, 32'h0, 1'b1);

      n = 0;
      while (n < RANDOM_ITEMS) begin
         if ($urandom_range(0, 299) == 0) begin
            // fill one block with extreme values, then sum across it
            blk = $urandom_range(0, NUM_BLOCKS - 1);
            for (int i = 0; i < BLOCK_SIZE; i++)
               add_item(OP_UPDATE, blk * BLOCK_SIZE + i, $urandom_range(0, 1023),
                        $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
            add_item(OP_QUERY, 0, DEPTH - 1, $urandom);
            add_item(OP_QUERY, blk * BLOCK_SIZE, blk * BLOCK_SIZE + BLOCK_SIZE - 1, $urandom);
            n += BLOCK_SIZE + 2;
         end else begin
            if ($urandom_range(0, 1) == 0)
               add_item(OP_UPDATE, pick_index(), $urandom_range(0, 1023), pick_value(),
                        ($urandom_range(0, 249) == 0));
            else
               add_random_query();
            n++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // acceptance and prediction happen together in the sender
      while (items_accepted != items_queued) @(posedge clock);
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d items: %0d updates, %0d queries (%0d across blocks, %0d reversed)",
               items_accepted, updates_seen, queries_seen, spanning_seen, reversed_seen);
      $display("%0d sums checked, %0d mismatches", sums_checked, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) element_shadow[i] = '0;
      for (int b = 0; b < NUM_BLOCKS; b++) block_sum_shadow[b] = '0;
   end

   // sender: one item held until accepted, then bursts and gaps
   logic        next_start;
   brs_req_type next_item;
   pending_type head;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         next_item = req_item;
         if (start && !busy) begin
            predict_item(req_item);
            items_accepted++;
            next_start = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               case ($urandom_range(0, 3))
                  0: gap_left = 0;
                  1, 2: gap_left = $urandom_range(1, 6);
                  default: gap_left = $urandom_range(7, 40);
               endcase
            end
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() != 0) begin
               if (!pending_items[0].hold || expected_sums.size() == 0) begin
                  head = pending_items.pop_front();
                  next_start = 1'b1;
                  next_item = head.item;
               end
            end
         end
         start <= next_start;
         req_item <= next_item;
      end
   end

   task automatic report_mismatch(string what, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at %0t: %s got %0d (0x%h), expected %0d (0x%h)", $realtime, what,
                  $signed(got), got, $signed(want), want);
   endtask

   // receiver: every strobed result is checked against the oldest expectation
   brs_rsp_type want_sum;
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_sums.size() == 0) begin
            report_mismatch("unexpected result, range_sum", rsp_item.range_sum, '0);
         end else begin
            want_sum = expected_sums.pop_front();
            sums_checked++;
            if (rsp_item.range_sum !== want_sum.range_sum)
               report_mismatch("range_sum", rsp_item.range_sum, want_sum.range_sum);
            if (rsp_item.range_error !== want_sum.range_error)
               report_mismatch("range_error", SUM_W'(rsp_item.range_error),
                               SUM_W'(want_sum.range_error));
         end
      end
   end

   // watchdog: cycles with neither an item nor a result accepted
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles, %0d results outstanding", idle_cycles,
                  expected_sums.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
